[rtl/core/assert_macros.svh]
// Assertion macros shared by the monitor RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`endif

[rtl/core/chm_pkg.sv]
// Shared types and constants of the cooling unit health monitor.
// No dependencies.
package chm_pkg;
  localparam logic [1:0] KIND_HOUR   = 2'd0;
  localparam logic [1:0] KIND_DAY    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] REG_DELAY   = 2'd0;
  localparam logic [1:0] REG_DIFF    = 2'd1;
  localparam logic [1:0] REG_FREEZE  = 2'd2;
  localparam logic [1:0] REG_PERSIST = 2'd3;
  // divider request/response
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

[rtl/core/chm_div.sv]
// Shared restoring divider: one quotient bit a cycle, unsigned magnitudes.
// Depends on chm_pkg for control structs.
module chm_div import chm_pkg::*; #(
  parameter int NB = 48,
  parameter int DB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  div_ctl_t      ctl,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output div_sts_t      sts,
  output logic [NB-1:0] quo
);
  localparam int CB = $clog2(NB + 1);
  logic [DB:0]   rem;
  logic [NB-1:0] nreg;
  logic [DB-1:0] dreg;
  logic [CB-1:0] cnt;
  logic          neg;
  logic [DB:0]   trial;

  assign trial = {rem[DB-1:0], nreg[NB-1]};

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        nreg     <= num;
        dreg     <= den;
        neg      <= ctl.neg;
        rem      <= '0;
        cnt      <= CB'(NB);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        if (trial >= {1'b0, dreg}) begin
          rem  <= trial - {1'b0, dreg};
          nreg <= {nreg[NB-2:0], 1'b1};
        end else begin
          rem  <= trial;
          nreg <= {nreg[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end
  assign quo = neg ? (~nreg + 1'b1) : nreg;
endmodule

[rtl/core/cooling_unit_health_monitor_unit.sv]
// Cooling unit health monitor: a plain sample is captured in S_IDLE and passes
// S_SUM, S_UPD and S_STAT, which registers the status beat; a boundary summary
// runs S_PCT, S_COLD, S_HOT and S_WAIT before S_UPD, with averages and
// percentages formed one quotient bit a cycle by one shared divider.
// One sample at a time; stall on the output holds the sequencer.
// Synchronous active-high reset restores register defaults, clears sums/latched alarms.
module cooling_unit_health_monitor_unit import chm_pkg::*; #(
  parameter int COUNT_BITS = 24,
  parameter int TEMP_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [TEMP_BITS-1:0] cold_side,
  input  logic signed [TEMP_BITS-1:0] hot_side,
  input  logic                        running,
  input  logic [31:0]                 now_seconds,
  input  logic                        hour_boundary,
  input  logic                        day_boundary,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  result_kind,
  output logic [9:0]                  percent_on_tenths,
  output logic                        on_share_valid,
  output logic signed [TEMP_BITS-1:0] average_cold,
  output logic signed [TEMP_BITS-1:0] average_hot,
  output logic                        averages_valid,
  output logic                        freeze_alarm,
  output logic                        difference_alarm,
  output logic                        disable_pulse,
  output logic                        checks_active,
  output logic                        last_of_run
);
  `include "assert_macros.svh"
  localparam int SB = COUNT_BITS + TEMP_BITS;
  localparam int NB = SB + 10;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_PCT, S_COLD, S_HOT, S_SUM, S_UPD, S_STAT, S_WAIT
  } state_t;
  state_t st;

  logic [15:0] start_delay_seconds;
  logic [11:0] min_difference;
  logic signed [11:0] freeze_limit;
  logic [7:0] persist_seconds;

  logic [COUNT_BITS-1:0] on_c [2];
  logic [COUNT_BITS-1:0] off_c [2];
  logic [COUNT_BITS-1:0] t_c [2];
  logic signed [SB-1:0] cs [2];
  logic signed [SB-1:0] hs [2];

  logic signed [TEMP_BITS-1:0] s_cold, s_hot;
  logic s_run, s_hb, s_db, prd, pulse;
  logic [31:0] s_now;
  logic previous_running, delay_pending, delay_done;
  logic [31:0] change_time, difference_start, freeze_start;
  logic difference_pending, difference_latched, freeze_pending, freeze_latched;
  logic waiting;

  div_ctl_t dctl;
  div_sts_t dsts;
  logic [NB-1:0] dnum, dq;
  logic [COUNT_BITS:0] dden;

  chm_div #(.NB(NB), .DB(COUNT_BITS + 1)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(dnum), .den(dden), .sts(dsts), .quo(dq)
  );

  // operand selection for the shared divider
  logic [COUNT_BITS:0] tot;
  logic signed [SB-1:0] sel_sum;
  assign tot = {1'b0, on_c[prd]} + {1'b0, off_c[prd]};
  assign sel_sum = (st == S_COLD) ? cs[prd] : hs[prd];
  always_comb begin
    dnum = '0;
    dden = {1'b0, t_c[prd]};
    dctl.neg = 1'b0;
    dctl.start = ((st == S_PCT && tot != '0) ||
                  ((st == S_COLD || st == S_HOT) && t_c[prd] != '0)) && !waiting;
    if (st == S_PCT) begin
      // on * 1000 as on * 1024 - on * 16 - on * 8
      dnum = NB'({on_c[prd], 10'd0}) - NB'({on_c[prd], 3'd0}) - NB'({on_c[prd], 4'd0});
      dden = tot;
    end else begin
      dnum = NB'(sel_sum[SB-1] ? -sel_sum : sel_sum);
      dctl.neg = sel_sum[SB-1];
    end
  end

  assign in_stall = (st != S_IDLE);

  // signed views for checks
  logic signed [TEMP_BITS+1:0] diff_v;
  assign diff_v = (TEMP_BITS+2)'(s_hot) - (TEMP_BITS+2)'(s_cold);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      start_delay_seconds <= 16'd60;
      min_difference <= 12'd480;
      freeze_limit <= 12'sd32;
      persist_seconds <= 8'd5;
      for (int i = 0; i < 2; i++) begin
        on_c[i] <= '0; off_c[i] <= '0; t_c[i] <= '0; cs[i] <= '0; hs[i] <= '0;
      end
      previous_running <= 1'b1;
      change_time <= '0; delay_pending <= 1'b0; delay_done <= 1'b0;
      difference_pending <= 1'b0; difference_start <= '0; difference_latched <= 1'b0;
      freeze_pending <= 1'b0; freeze_start <= '0; freeze_latched <= 1'b0;
      out_valid <= 1'b0; waiting <= 1'b0; prd <= 1'b0;
      pulse <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DELAY:   start_delay_seconds <= cfg_data;
          REG_DIFF:    min_difference <= cfg_data[11:0];
          REG_FREEZE:  freeze_limit <= cfg_data[11:0];
          REG_PERSIST: persist_seconds <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            s_cold <= cold_side; s_hot <= hot_side; s_run <= running;
            s_now <= now_seconds; s_hb <= hour_boundary; s_db <= day_boundary;
            st <= S_SUM;
          end
        end
        S_SUM: begin
          // output fields are reused only once the previous beat has left
          if (!out_valid) begin
            if (s_hb) begin prd <= 1'b0; st <= S_PCT; s_hb <= 1'b0; end
            else if (s_db) begin prd <= 1'b1; st <= S_PCT; s_db <= 1'b0; end
            else st <= S_UPD;
            result_kind <= s_hb ? KIND_HOUR : KIND_DAY;
            percent_on_tenths <= '0; on_share_valid <= 1'b0;
            average_cold <= '0; average_hot <= '0; averages_valid <= 1'b0;
            waiting <= 1'b0;
          end
        end
        S_PCT, S_COLD, S_HOT: begin
          if (dctl.start) waiting <= 1'b1;
          else if (!waiting) begin
            st <= (st == S_PCT) ? S_COLD : (st == S_COLD) ? S_HOT : S_WAIT;
          end else if (dsts.done) begin
            waiting <= 1'b0;
            if (st == S_PCT) begin
              percent_on_tenths <= dq[9:0]; on_share_valid <= 1'b1; st <= S_COLD;
            end else if (st == S_COLD) begin
              average_cold <= dq[TEMP_BITS-1:0]; averages_valid <= 1'b1; st <= S_HOT;
            end else begin
              average_hot <= dq[TEMP_BITS-1:0]; st <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            freeze_alarm <= 1'b0; difference_alarm <= 1'b0; disable_pulse <= 1'b0;
            checks_active <= 1'b0; last_of_run <= 1'b0;
            on_c[prd] <= '0; off_c[prd] <= '0; t_c[prd] <= '0;
            cs[prd] <= '0; hs[prd] <= '0;
            st <= S_SUM;
          end
        end
        S_UPD: begin
          for (int i = 0; i < 2; i++) begin
            if (s_run) begin
              if (on_c[i] != CMAX) on_c[i] <= on_c[i] + 1'b1;
              if (delay_done && t_c[i] != CMAX) begin
                t_c[i] <= t_c[i] + 1'b1;
                cs[i] <= cs[i] + SB'(s_cold);
                hs[i] <= hs[i] + SB'(s_hot);
              end
            end else if (off_c[i] != CMAX) off_c[i] <= off_c[i] + 1'b1;
          end
          begin
            logic dd, dp, p;
            dd = delay_done; dp = delay_pending; p = 1'b0;
            if (dp && (s_now - change_time) > ({16'd0, start_delay_seconds} + 32'd1)) begin
              dd = 1'b1; dp = 1'b0;
            end
            if (s_run != previous_running) begin
              previous_running <= s_run; change_time <= s_now;
              if (s_run) dp = 1'b1;
              dd = 1'b0;
            end
            if (dd) begin
              if (int'(diff_v) < int'(min_difference)) begin
                if (!difference_pending) begin
                  difference_pending <= 1'b1; difference_start <= s_now;
                end else if ((s_now - difference_start) > {24'd0, persist_seconds}
                             && !difference_latched) begin
                  difference_latched <= 1'b1; p = 1'b1;
                end
              end else begin
                difference_pending <= 1'b0; difference_start <= '0;
              end
              if (s_cold < freeze_limit) begin
                if (!freeze_pending) begin
                  freeze_pending <= 1'b1; freeze_start <= s_now;
                end else if ((s_now - freeze_start) > {24'd0, persist_seconds}
                             && !freeze_latched) begin
                  freeze_latched <= 1'b1; p = 1'b1;
                end
              end else begin
                freeze_pending <= 1'b0; freeze_start <= '0;
              end
            end
            delay_done <= dd; delay_pending <= dp; pulse <= p;
          end
          st <= S_STAT;
        end
        S_STAT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            result_kind <= KIND_STATUS;
            freeze_alarm <= freeze_latched; difference_alarm <= difference_latched;
            disable_pulse <= pulse; checks_active <= delay_done; last_of_run <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_stall_busy, clk, rst, st != S_IDLE, in_stall)
  `ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_kind))
  `ASSERT_IMP(a_pulse, clk, rst, out_valid && disable_pulse, freeze_alarm || difference_alarm)
endmodule
